FILE: rtl/core/dmrc_pkg.sv
// Shared constants and codes of the direct-mapped read cache.
package dmrc_pkg;

  // Geometry
  localparam int NUM_LINES      = 4;
  localparam int BYTES_PER_LINE = 8;
  localparam int MEMORY_BYTES   = 1024;

  localparam int WORD_W  = $clog2(BYTES_PER_LINE);
  localparam int LINE_W  = $clog2(NUM_LINES);
  localparam int ADDR_W  = $clog2(MEMORY_BYTES);
  localparam int TAG_W   = ADDR_W - LINE_W - WORD_W;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 32;
  localparam int REG_W   = 8;
  localparam int FILL_CNT_W = WORD_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_TIME  = 1'b1;
  localparam logic [REG_W-1:0] MISS_PENALTY_RESET = 8'd10;
  localparam logic [REG_W-1:0] ACCESS_TIME_RESET  = 8'd1;

  // Request opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ACCESS = 1'b1;

endpackage

FILE: rtl/core/dmrc_channels.sv
// Request and response channel interfaces of the direct-mapped read cache.
interface dmrc_req_if;
  import dmrc_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] load_byte;

  modport source (output valid, opcode, address, load_byte, input ready);
  modport sink   (input valid, opcode, address, load_byte, output ready);
endinterface

interface dmrc_rsp_if;
  import dmrc_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [TAG_W-1:0]  tag_field;
  logic [LINE_W-1:0] line_field;
  logic [WORD_W-1:0] word_field;
  logic [BYTE_W-1:0] read_data;
  logic [CNT_W-1:0]  miss_total;
  logic [CNT_W-1:0]  elapsed_time;

  modport source (output valid, hit, tag_field, line_field, word_field, read_data,
                  miss_total, elapsed_time, input ready);
  modport sink   (input valid, hit, tag_field, line_field, word_field, read_data,
                  miss_total, elapsed_time, output ready);
endinterface

FILE: rtl/core/direct_mapped_read_cache_core.sv
// Top level of the direct-mapped read cache core.
// A read-only cache of 4 lines of 8 bytes in front of a 1024-byte backing memory.
// A load word writes one backing byte in the cycle it is accepted and gives no
// response. An access word is accepted and its tag looked up; a hit goes
// straight to the last step, while a miss first bumps the miss count, adds the
// penalty and copies the aligned block out of the backing memory (registered
// read, one byte a cycle). The last step adds the access time and registers the
// response once the output register is free. All time and miss arithmetic runs
// through one shared saturating 32-bit adder. The next request is taken while a
// response still waits in the output register. Bytes of the backing memory must
// be loaded before an access brings them into a line.
module direct_mapped_read_cache_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dmrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmrc_pkg::REG_W-1:0]     cfg_data,
  dmrc_req_if.sink                       req,
  dmrc_rsp_if.source                     rsp
);
  import dmrc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MISS = 5'b00010,
    S_PEN  = 5'b00100,
    S_FILL = 5'b01000,
    S_ACC  = 5'b10000
  } state_t;

  localparam logic [FILL_CNT_W-1:0] FILL_LAST = FILL_CNT_W'(BYTES_PER_LINE);

  state_t                  state;
  logic [REG_W-1:0]        miss_penalty;
  logic [REG_W-1:0]        access_time;
  logic [CNT_W-1:0]        miss_counter;
  logic [CNT_W-1:0]        time_counter;
  logic [NUM_LINES-1:0]    line_valid;
  logic [TAG_W-1:0]        line_tag [NUM_LINES];
  logic [BYTE_W-1:0]       line_bytes [NUM_LINES*BYTES_PER_LINE];
  logic [BYTE_W-1:0]       backing [MEMORY_BYTES];
  logic [BYTE_W-1:0]       mem_q;
  logic [ADDR_W-1:0]       addr_q;
  logic                    hit_q;
  logic [FILL_CNT_W-1:0]   fill_cnt;
  logic [FILL_CNT_W-1:0]   fill_prev;

  // Response register
  logic                    out_valid;
  logic                    out_hit;
  logic [TAG_W-1:0]        out_tag;
  logic [LINE_W-1:0]       out_line;
  logic [WORD_W-1:0]       out_word;
  logic [BYTE_W-1:0]       out_data;
  logic [CNT_W-1:0]        out_miss;
  logic [CNT_W-1:0]        out_time;

  // Request decode
  logic                    load_fire;
  logic                    access_fire;
  logic [TAG_W-1:0]        req_tag;
  logic [LINE_W-1:0]       req_line;
  logic                    hit_now;
  logic [TAG_W-1:0]        tag_q;
  logic [LINE_W-1:0]       line_q;
  logic [WORD_W-1:0]       word_q;
  logic [ADDR_W-1:0]       fill_addr;
  logic                    out_free;

  // Shared saturating adder
  logic [CNT_W-1:0]        add_a;
  logic [CNT_W-1:0]        add_b;
  logic [CNT_W:0]          add_sum;
  logic [CNT_W-1:0]        add_sat;

  assign req.ready   = (state == S_IDLE);
  assign load_fire   = req.valid && req.ready && (req.opcode == OP_LOAD);
  assign access_fire = req.valid && req.ready && (req.opcode == OP_ACCESS);
  assign req_tag     = req.address[ADDR_W-1 -: TAG_W];
  assign req_line    = req.address[WORD_W +: LINE_W];
  assign hit_now     = line_valid[req_line] && (line_tag[req_line] == req_tag);

  assign tag_q     = addr_q[ADDR_W-1 -: TAG_W];
  assign line_q    = addr_q[WORD_W +: LINE_W];
  assign word_q    = addr_q[WORD_W-1:0];
  assign fill_addr = {addr_q[ADDR_W-1:WORD_W], fill_cnt[WORD_W-1:0]};
  assign fill_prev = fill_cnt - FILL_CNT_W'(1);
  assign out_free  = !out_valid || rsp.ready;

  // Operand select: miss count, penalty, or access time
  always_comb begin
    unique case (state)
      S_MISS: begin
        add_a = miss_counter;
        add_b = CNT_W'(1);
      end
      S_PEN: begin
        add_a = time_counter;
        add_b = {{(CNT_W-REG_W){1'b0}}, miss_penalty};
      end
      default: begin
        add_a = time_counter;
        add_b = {{(CNT_W-REG_W){1'b0}}, access_time};
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_sat = add_sum[CNT_W] ? {CNT_W{1'b1}} : add_sum[CNT_W-1:0];

  // Backing memory: load writes, registered read for line fill
  always_ff @(posedge clk) begin
    if (load_fire) begin
      backing[req.address] <= req.load_byte;
    end
    mem_q <= backing[fill_addr];
  end

  // Line data: one byte written per fill cycle, from the registered memory read (mem_q)
  always_ff @(posedge clk) begin
    if ((state == S_FILL) && (fill_cnt != '0)) begin
      line_bytes[{line_q, fill_prev[WORD_W-1:0]}] <= mem_q;
    end
  end

  // Sequencer, counters, tags and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      miss_penalty <= MISS_PENALTY_RESET;
      access_time  <= ACCESS_TIME_RESET;
      miss_counter <= '0;
      time_counter <= '0;
      line_valid   <= '0;
      fill_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MISS_PENALTY: miss_penalty <= cfg_data;
          CFG_ACCESS_TIME:  access_time  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (access_fire) begin
            addr_q <= req.address;
            hit_q  <= hit_now;
            state  <= hit_now ? S_ACC : S_MISS;
          end
        end
        S_MISS: begin
          miss_counter <= add_sat;
          state        <= S_PEN;
        end
        S_PEN: begin
          time_counter <= add_sat;
          fill_cnt     <= '0;
          state        <= S_FILL;
        end
        S_FILL: begin
          if (fill_cnt == FILL_LAST) begin
            line_tag[line_q]   <= tag_q;
            line_valid[line_q] <= 1'b1;
            state              <= S_ACC;
          end else begin
            fill_cnt <= fill_cnt + FILL_CNT_W'(1);
          end
        end
        S_ACC: begin
          if (out_free) begin
            time_counter <= add_sat;
            out_valid    <= 1'b1;
            out_hit      <= hit_q;
            out_tag      <= tag_q;
            out_line     <= line_q;
            out_word     <= word_q;
            out_data     <= line_bytes[{line_q, word_q}];
            out_miss     <= miss_counter;
            out_time     <= add_sat;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.tag_field    = out_tag;
  assign rsp.line_field   = out_line;
  assign rsp.word_field   = out_word;
  assign rsp.read_data    = out_data;
  assign rsp.miss_total   = out_miss;
  assign rsp.elapsed_time = out_time;

endmodule

FILE: rtl/core/dmrc_checker.sv
// Port-level checks of the direct-mapped read cache, bound to the top level.
module dmrc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_hit,
  input logic [dmrc_pkg::CNT_W-1:0] rsp_miss_total,
  input logic [dmrc_pkg::CNT_W-1:0] rsp_elapsed_time
);
  import dmrc_pkg::*;

  logic             rsp_fire;
  logic [CNT_W-1:0] last_miss;
  logic [CNT_W-1:0] last_time;

  assign rsp_fire = rsp_valid && rsp_ready;

  // Counters seen on the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_miss <= '0;
      last_time <= '0;
    end else if (rsp_fire) begin
      last_miss <= rsp_miss_total;
      last_time <= rsp_elapsed_time;
    end
  end

  // A waiting response stays up
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response valid dropped while stalled");

  // A hit does not move the miss count
  a_hit_no_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_fire && rsp_hit |-> rsp_miss_total == last_miss)
    else $error("miss count changed on a hit");

  // A miss moves it by one unless saturated
  a_miss_step: assert property (@(posedge clk) disable iff (rst)
    rsp_fire && !rsp_hit |->
      (rsp_miss_total == last_miss + CNT_W'(1)) || (last_miss == {CNT_W{1'b1}}))
    else $error("miss count did not advance by one on a miss");

  // Elapsed time never goes back
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> rsp_elapsed_time >= last_time)
    else $error("elapsed time decreased");

endmodule

bind direct_mapped_read_cache_core dmrc_checker u_dmrc_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_hit          (rsp.hit),
  .rsp_miss_total   (rsp.miss_total),
  .rsp_elapsed_time (rsp.elapsed_time)
);
